// File: src/kwm_pkg.sv
// Shared types and constants for the sorted stream merger.
package kwm_pkg;

	localparam int unsigned LANE_W  = 3;
	localparam int unsigned ID_W    = 64;
	localparam int unsigned QUAL_W  = 23;
	localparam int unsigned COUNT_W = 4;
	localparam int unsigned ADDR_LANES = 8;
	localparam int unsigned Q_DEPTH = 2;
	localparam logic [QUAL_W-1:0] QUALITY_MAX = 23'd6553600;

	// Classified input beat handed from the front to the back end
	typedef struct packed {
		logic [LANE_W-1:0] lane;
		logic              in_range;
		logic              eos;
		logic [ID_W-1:0]   id;
		logic [QUAL_W-1:0] qual;
	} kwm_op_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EVAL
	} kwm_state_t;

endpackage

// File: src/kwm_front.sv
// Front end: classify each input beat and saturate its quality.
module kwm_front
	import kwm_pkg::*;
(
	input  logic [LANE_W-1:0]  lane,
	input  logic               end_of_stream,
	input  logic [ID_W-1:0]    record_id,
	input  logic [QUAL_W-1:0]  quality,
	input  logic [COUNT_W-1:0] lanes_used,
	output kwm_op_t            op
);

	// Check the lane against the active count, clamp the quality
	always_comb begin
		op.lane     = lane;
		op.in_range = ({1'b0, lane} < lanes_used);
		op.eos      = end_of_stream;
		op.id       = record_id;
		op.qual     = (quality > QUALITY_MAX) ? QUALITY_MAX : quality;
	end

endmodule

// File: src/kwm_fifo.sv
// Short queue of classified beats between the front and back ends.
module kwm_fifo
	import kwm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  kwm_op_t push_op,
	output logic    full,
	input  logic    pop,
	output logic    empty,
	output kwm_op_t pop_op
);

	localparam int unsigned PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

	kwm_op_t         mem_q [Q_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign full   = (count_q == (PW+1)'(Q_DEPTH));
	assign empty  = (count_q == '0);
	assign pop_op = mem_q[rd_ptr_q];

	// Store the pushed beat
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/kwm_back.sv
// Back end: head table, pairwise order bits, winner choice and output register.
module kwm_back
	import kwm_pkg::*;
#(
	parameter int unsigned NL = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  kwm_op_t            q_op,
	output logic               q_pop,
	input  logic [COUNT_W-1:0] lanes_used,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ID_W-1:0]    record_id_out,
	output logic [QUAL_W-1:0]  quality_out,
	output logic [LANE_W-1:0]  source_lane,
	output logic               all_done
);

	localparam int unsigned LW = (NL > 1) ? $clog2(NL) : 1;

	kwm_state_t state_q, state_d;

	logic [ID_W-1:0]   head_id_q   [NL];
	logic [QUAL_W-1:0] head_qual_q [NL];
	logic [NL-1:0]     head_full_q;
	logic [NL-1:0]     lane_ended_q;
	logic [NL-1:0]     beats_q     [NL];
	logic              finished_q;

	logic              apply_en;
	logic              emit_en;
	logic              out_free;
	logic [LW-1:0]     op_lane;
	logic              do_end;
	logic              do_fill;
	logic [NL-1:0]     fill_beats;
	logic [NL-1:0]     in_use;
	logic [NL-1:0]     win;
	logic [LW-1:0]     best;
	logic              any_head;
	logic              waiting;

	assign op_lane  = q_op.lane[LW-1:0];
	assign out_free = !out_valid || out_ready;

	// Decode the popped beat against the lane state
	always_comb begin
		do_end  = 1'b0;
		do_fill = 1'b0;
		if (apply_en && q_op.in_range && !lane_ended_q[op_lane]) begin
			do_end  = q_op.eos;
			do_fill = !q_op.eos && !head_full_q[op_lane];
		end
	end

	// Compare the new id with every other head, lower lane wins a tie
	always_comb begin
		for (int j = 0; j < NL; j++) begin
			if (LW'(j) > op_lane) begin
				fill_beats[j] = (q_op.id <= head_id_q[j]);
			end else begin
				fill_beats[j] = (q_op.id < head_id_q[j]);
			end
		end
	end

	// Find the head that beats every other full head
	always_comb begin
		for (int k = 0; k < NL; k++) begin
			in_use[k] = (COUNT_W'(k) < lanes_used);
		end
		for (int k = 0; k < NL; k++) begin
			win[k] = head_full_q[k] && in_use[k];
			for (int j = 0; j < NL; j++) begin
				if (j != k && head_full_q[j] && in_use[j] && !beats_q[k][j]) begin
					win[k] = 1'b0;
				end
			end
		end
		best = '0;
		for (int k = NL - 1; k >= 0; k--) begin
			if (win[k]) begin
				best = LW'(k);
			end
		end
		any_head = |(head_full_q & in_use);
		waiting  = |(~head_full_q & ~lane_ended_q & in_use);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (finished_q || waiting || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		q_pop    = 1'b0;
		apply_en = 1'b0;
		emit_en  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				q_pop    = !q_empty;
				apply_en = !q_empty && !finished_q;
			end
			ST_EVAL: begin
				emit_en = !finished_q && !waiting && out_free;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// Write head payload and order bits on a fill
	always_ff @(posedge clk) begin
		if (do_fill) begin
			head_id_q[op_lane]   <= q_op.id;
			head_qual_q[op_lane] <= q_op.qual;
			for (int j = 0; j < NL; j++) begin
				if (LW'(j) != op_lane) begin
					beats_q[op_lane][j] <= fill_beats[j];
					beats_q[j][op_lane] <= !fill_beats[j];
				end
			end
		end
	end

	// Load the result beat
	always_ff @(posedge clk) begin
		if (emit_en) begin
			if (any_head) begin
				record_id_out <= head_id_q[best];
				quality_out   <= head_qual_q[best];
				source_lane   <= LANE_W'(best);
				all_done      <= 1'b0;
			end else begin
				record_id_out <= '0;
				quality_out   <= '0;
				source_lane   <= '0;
				all_done      <= 1'b1;
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_full_q  <= '0;
			lane_ended_q <= '0;
			finished_q   <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_end) begin
				lane_ended_q[op_lane] <= 1'b1;
			end
			if (do_fill) begin
				head_full_q[op_lane] <= 1'b1;
			end
			if (emit_en) begin
				out_valid <= 1'b1;
				if (any_head) begin
					head_full_q[best] <= 1'b0;
				end else begin
					finished_q <= 1'b1;
				end
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

// File: src/k_way_sorted_stream_merger.sv
// Top level of the sorted stream merger: config register, front, queue, back.
// Path: a beat that causes a result passes the queue, the head table and the output register.
// Beat flow: the back end pops a new beat only after its apply step and its winner evaluation
// over the head table for the last beat; a full output register stalls evaluation.
// Reset: asynchronous, clears queue, valid/ended flags and done flag, active_lanes = 1;
// head records stay undefined until written.
module k_way_sorted_stream_merger
	import kwm_pkg::*;
#(
	parameter int unsigned LANES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [LANE_W-1:0]  lane,
	input  logic               end_of_stream,
	input  logic [ID_W-1:0]    record_id,
	input  logic [QUAL_W-1:0]  quality,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ID_W-1:0]    record_id_out,
	output logic [QUAL_W-1:0]  quality_out,
	output logic [LANE_W-1:0]  source_lane,
	output logic               all_done
);

	localparam int unsigned NL = (LANES < ADDR_LANES) ? LANES : ADDR_LANES;

	logic [COUNT_W-1:0] active_lanes_q;
	logic [COUNT_W-1:0] lanes_used;
	kwm_op_t            front_op;
	kwm_op_t            q_op;
	logic               q_full;
	logic               q_empty;
	logic               q_pop;

	// Hold the lane count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_lanes_q <= COUNT_W'(1);
		end else if (cfg_we) begin
			active_lanes_q <= cfg_wdata;
		end
	end

	// Clamp the lane count to the addressable range
	always_comb begin
		if (active_lanes_q == '0) begin
			lanes_used = COUNT_W'(1);
		end else if (active_lanes_q > COUNT_W'(NL)) begin
			lanes_used = COUNT_W'(NL);
		end else begin
			lanes_used = active_lanes_q;
		end
	end

	assign in_ready = !q_full;

	kwm_front u_front (
		.lane          (lane),
		.end_of_stream (end_of_stream),
		.record_id     (record_id),
		.quality       (quality),
		.lanes_used    (lanes_used),
		.op            (front_op)
	);

	kwm_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (in_valid && !q_full),
		.push_op (front_op),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.pop_op  (q_op)
	);

	kwm_back #(
		.NL (NL)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_op          (q_op),
		.q_pop         (q_pop),
		.lanes_used    (lanes_used),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.record_id_out (record_id_out),
		.quality_out   (quality_out),
		.source_lane   (source_lane),
		.all_done      (all_done)
	);

	// Final beat carries no record
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && all_done |->
			record_id_out == '0 && quality_out == '0 && source_lane == '0)
		else $error("final beat carries record data");

	// Emitted quality stays within the saturated range
	a_qual_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> quality_out <= QUALITY_MAX)
		else $error("quality above saturation limit");

	// Nothing follows the final beat
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && all_done |=> !out_valid)
		else $error("result after final beat");

	// Emitted lane lies within the active lane count
	a_lane_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !all_done |-> {1'b0, source_lane} < lanes_used)
		else $error("result from inactive lane");

endmodule
